### design/prd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase residue detector package
// Shared widths, defaults, register indexes and residue codes.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PHASE_BITS_DEF = 16;
    localparam int FLAG_BITS      = 8;
    localparam int COUNT_BITS     = 24;
    localparam int ROW_BITS       = 12;
    localparam int QCOL_BITS      = 11;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int RES_BITS       = 2;

    localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST    = 12'd2048;
    localparam logic [FLAG_BITS-1:0]  INVALID_MASK_RST = 8'd1;
    localparam logic [FLAG_BITS-1:0]  PLUS_MARK_RST    = 8'd2;
    localparam logic [FLAG_BITS-1:0]  MINUS_MARK_RST   = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH    = 2'd0,
        REG_INVALID_MASK = 2'd1,
        REG_PLUS_MARK    = 2'd2,
        REG_MINUS_MARK   = 2'd3
    } cfg_idx_t;

    typedef enum logic [RES_BITS-1:0] {
        RES_NONE  = 2'd0,
        RES_PLUS  = 2'd1,
        RES_MINUS = 2'd2
    } residue_t;

endpackage

### design/prd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase residue detector channels
// Pixel input channel and quad result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prd_in_if #(
    parameter int PHASE_BITS = prd_pkg::PHASE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [PHASE_BITS-1:0]          phase;
    logic [prd_pkg::FLAG_BITS-1:0]  flags;
    logic                           first_of_frame;

    modport source (output valid, phase, flags, first_of_frame, input ready);
    modport sink   (input valid, phase, flags, first_of_frame, output ready);
endinterface

interface prd_out_if;
    logic                           valid;
    logic                           ready;
    logic [prd_pkg::ROW_BITS-1:0]   quad_row;
    logic [prd_pkg::QCOL_BITS-1:0]  quad_col;
    logic [prd_pkg::FLAG_BITS-1:0]  flags_out;
    logic [prd_pkg::RES_BITS-1:0]   residue;
    logic [prd_pkg::COUNT_BITS-1:0] plus_count;
    logic [prd_pkg::COUNT_BITS-1:0] minus_count;
    logic [prd_pkg::COUNT_BITS-1:0] total_count;

    modport source (output valid, quad_row, quad_col, flags_out, residue,
                    plus_count, minus_count, total_count, input ready);
    modport sink   (input valid, quad_row, quad_col, flags_out, residue,
                    plus_count, minus_count, total_count, output ready);
endinterface

### design/phase_residue_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase residue detector
// Raster-order wrapped phase in, one line buffer memory, 2x2 quad residues
// with saturating per-frame counts out.
// ----------------------------------------------------------------------------
// Pipeline: a pixel transaction passes the line buffer read stage (stage A),
// then the output register; a stalled result channel holds stage A.
// Throughput: one pixel per cycle unless a result stalls; the line buffer
// does one read and one write per pixel at the same column (read-first).
// Reset: control, configuration, indexes and counts clear at once; the line
// buffer is not cleared and holds no valid bits.
// ----------------------------------------------------------------------------
module phase_residue_detector #(
    parameter int MAX_WIDTH  = prd_pkg::MAX_WIDTH_DEF,
    parameter int PHASE_BITS = prd_pkg::PHASE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    prd_in_if.sink                           pixel,
    prd_out_if.source                        quad,
    input  logic                             cfg_we,
    input  logic [prd_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [prd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int FB     = prd_pkg::FLAG_BITS;
    localparam int CB     = prd_pkg::COUNT_BITS;
    localparam int RB     = prd_pkg::ROW_BITS;
    localparam int QCB    = prd_pkg::QCOL_BITS;
    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WW > prd_pkg::CFG_DATA_W) ? WW : prd_pkg::CFG_DATA_W;
    localparam int QC_W   = (COL_W > QCB) ? COL_W : QCB;
    localparam int ENT_W  = PHASE_BITS + FB;
    localparam int SUM_W  = PHASE_BITS + 3;
    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    // configuration
    logic [prd_pkg::CFG_DATA_W-1:0] row_width_reg;
    logic [FB-1:0]                  invalid_mask_reg;
    logic [FB-1:0]                  plus_mark_reg;
    logic [FB-1:0]                  minus_mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= prd_pkg::ROW_WIDTH_RST;
            invalid_mask_reg <= prd_pkg::INVALID_MASK_RST;
            plus_mark_reg    <= prd_pkg::PLUS_MARK_RST;
            minus_mark_reg   <= prd_pkg::MINUS_MARK_RST;
        end
        else if (cfg_we)
        begin
            unique case (prd_pkg::cfg_idx_t'(cfg_idx))
                prd_pkg::REG_ROW_WIDTH:    row_width_reg    <= cfg_data;
                prd_pkg::REG_INVALID_MASK: invalid_mask_reg <= FB'(cfg_data);
                prd_pkg::REG_PLUS_MARK:    plus_mark_reg    <= FB'(cfg_data);
                prd_pkg::REG_MINUS_MARK:   minus_mark_reg   <= FB'(cfg_data);
            endcase
        end
    end

    // front: column and row tracking, line buffer access
    logic             acc;
    logic             b_go;
    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [RB-1:0]    row_reg, row_next, row_cur;
    logic [CMP_W-1:0] rw_ext, width_eff, col_plus;
    logic             emit_cur;

    assign acc = pixel.valid && pixel.ready;

    always_comb
    begin
        col_cur  = pixel.first_of_frame ? '0 : col_reg;
        row_cur  = pixel.first_of_frame ? '0 : row_reg;
        emit_cur = (row_cur != '0) && (col_cur != '0);
        rw_ext   = CMP_W'(row_width_reg);
        if (rw_ext < CMP_W'(2))
            width_eff = CMP_W'(2);
        else if (rw_ext > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = rw_ext;
        col_plus = CMP_W'(col_cur) + CMP_W'(1);
        if (col_plus >= width_eff)
        begin
            col_next = '0;
            row_next = row_cur + RB'(1);
        end
        else
        begin
            col_next = COL_W'(col_plus);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    logic [ENT_W-1:0] line_mem [MAX_WIDTH];
    logic [ENT_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            line_mem[col_cur] <= {pixel.phase, pixel.flags};
            rd_reg            <= line_mem[col_cur];
        end
    end

    // stage A: item waiting for line buffer data
    logic                  a_valid_reg;
    logic [PHASE_BITS-1:0] a_ph_reg;
    logic [FB-1:0]         a_fl_reg;
    logic                  a_first_reg;
    logic                  a_emit_reg;
    logic [RB-1:0]         a_qrow_reg;
    logic [QCB-1:0]        a_qcol_reg;
    logic                  out_valid_reg;

    assign b_go        = a_valid_reg && (!a_emit_reg || !out_valid_reg || quad.ready);
    assign pixel.ready = !a_valid_reg || b_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (acc)
            a_valid_reg <= 1'b1;
        else if (b_go)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_ph_reg    <= pixel.phase;
            a_fl_reg    <= pixel.flags;
            a_first_reg <= pixel.first_of_frame;
            a_emit_reg  <= emit_cur;
            a_qrow_reg  <= row_cur - RB'(1);
            a_qcol_reg  <= QCB'(QC_W'(col_cur) - QC_W'(1));
        end
    end

    // stage B: quad evaluation
    function automatic logic signed [PHASE_BITS:0] wrap_diff(
        input logic [PHASE_BITS-1:0] b,
        input logic [PHASE_BITS-1:0] a
    );
        logic [PHASE_BITS-1:0] d;
        d = b - a;
        if (d == {1'b1, {(PHASE_BITS-1){1'b0}}})
            return {1'b0, d};
        else
            return {d[PHASE_BITS-1], d};
    endfunction

    logic [PHASE_BITS-1:0]   up_ph, ul_ph_reg, left_ph_reg;
    logic [FB-1:0]           up_fl, ul_fl_reg, left_fl_reg;
    logic signed [SUM_W-1:0] loop_sum;
    logic                    quad_ok;
    logic [CB-1:0]           plus_reg, minus_reg, p_new, m_new;
    logic [CB:0]             tot_raw;
    logic [CB-1:0]           tot_new;
    logic [FB-1:0]           fo_new;
    prd_pkg::residue_t       res_new;

    assign up_ph = rd_reg[ENT_W-1:FB];
    assign up_fl = rd_reg[FB-1:0];

    always_comb
    begin
        loop_sum = SUM_W'(wrap_diff(up_ph, ul_ph_reg))
                 + SUM_W'(wrap_diff(a_ph_reg, up_ph))
                 + SUM_W'(wrap_diff(left_ph_reg, a_ph_reg))
                 + SUM_W'(wrap_diff(ul_ph_reg, left_ph_reg));
        quad_ok  = a_emit_reg
                 && ((ul_fl_reg & invalid_mask_reg) == '0)
                 && ((up_fl & invalid_mask_reg) == '0)
                 && ((left_fl_reg & invalid_mask_reg) == '0)
                 && ((a_fl_reg & invalid_mask_reg) == '0);
        p_new   = a_first_reg ? '0 : plus_reg;
        m_new   = a_first_reg ? '0 : minus_reg;
        fo_new  = ul_fl_reg;
        res_new = prd_pkg::RES_NONE;
        if (quad_ok && !loop_sum[SUM_W-1] && (loop_sum != '0))
        begin
            res_new = prd_pkg::RES_PLUS;
            fo_new  = ul_fl_reg | plus_mark_reg;
            if (p_new != COUNT_MAX)
                p_new = p_new + CB'(1);
        end
        else if (quad_ok && loop_sum[SUM_W-1])
        begin
            res_new = prd_pkg::RES_MINUS;
            fo_new  = ul_fl_reg | minus_mark_reg;
            if (m_new != COUNT_MAX)
                m_new = m_new + CB'(1);
        end
        tot_raw = {1'b0, p_new} + {1'b0, m_new};
        tot_new = tot_raw[CB] ? COUNT_MAX : tot_raw[CB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_ph_reg   <= '0;
            ul_fl_reg   <= '0;
            left_ph_reg <= '0;
            left_fl_reg <= '0;
            plus_reg    <= '0;
            minus_reg   <= '0;
        end
        else if (b_go)
        begin
            ul_ph_reg   <= up_ph;
            ul_fl_reg   <= up_fl;
            left_ph_reg <= a_ph_reg;
            left_fl_reg <= a_fl_reg;
            plus_reg    <= p_new;
            minus_reg   <= m_new;
        end
    end

    // output register
    logic                 out_valid_next;
    logic [RB-1:0]        o_row_reg;
    logic [QCB-1:0]       o_col_reg;
    logic [FB-1:0]        o_flags_reg;
    prd_pkg::residue_t    o_res_reg;
    logic [CB-1:0]        o_plus_reg, o_minus_reg, o_total_reg;

    always_comb
    begin
        if (b_go && a_emit_reg)
            out_valid_next = 1'b1;
        else if (quad.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_go && a_emit_reg)
        begin
            o_row_reg   <= a_qrow_reg;
            o_col_reg   <= a_qcol_reg;
            o_flags_reg <= fo_new;
            o_res_reg   <= res_new;
            o_plus_reg  <= p_new;
            o_minus_reg <= m_new;
            o_total_reg <= tot_new;
        end
    end

    assign quad.valid       = out_valid_reg;
    assign quad.quad_row    = o_row_reg;
    assign quad.quad_col    = o_col_reg;
    assign quad.flags_out   = o_flags_reg;
    assign quad.residue     = o_res_reg;
    assign quad.plus_count  = o_plus_reg;
    assign quad.minus_count = o_minus_reg;
    assign quad.total_count = o_total_reg;

endmodule

### design/prd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase residue detector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module prd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [prd_pkg::RES_BITS-1:0]     residue,
    input logic [prd_pkg::FLAG_BITS-1:0]    flags_out,
    input logic [prd_pkg::COUNT_BITS-1:0]   plus_count,
    input logic [prd_pkg::COUNT_BITS-1:0]   minus_count,
    input logic [prd_pkg::COUNT_BITS-1:0]   total_count
);

    localparam int CB = prd_pkg::COUNT_BITS;

    logic [CB:0] count_sum;
    assign count_sum = {1'b0, plus_count} + {1'b0, minus_count};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residue)
            && $stable(flags_out) && $stable(total_count))
        else $error("result changed while stalled");

    a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_sum[CB] ? (total_count == {CB{1'b1}})
                                     : (total_count == count_sum[CB-1:0])))
        else $error("total count is not the saturated sum");

    a_plus_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (residue == prd_pkg::RES_PLUS) |-> plus_count != '0)
        else $error("positive residue with zero positive count");

    a_minus_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (residue == prd_pkg::RES_MINUS) |-> minus_count != '0)
        else $error("negative residue with zero negative count");

endmodule

bind phase_residue_detector prd_checker u_prd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (quad.valid),
    .out_ready   (quad.ready),
    .residue     (quad.residue),
    .flags_out   (quad.flags_out),
    .plus_count  (quad.plus_count),
    .minus_count (quad.minus_count),
    .total_count (quad.total_count)
);
